// File: design/gregorian_persian_date_converter_assert.svh
// Assertion macros shared by the date converter RTL.
`ifndef GREGORIAN_PERSIAN_DATE_CONVERTER_ASSERT_SVH
`define GREGORIAN_PERSIAN_DATE_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked on aclk, off while aresetn is low.
`define GPDC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gpdc assertion failed");

// Next-cycle implication, checked on aclk, off while aresetn is low.
`define GPDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gpdc assertion failed");

`endif

// File: design/gpdc_pkg.sv
// Constants, calendar tables and table lookups for the date converter.
`default_nettype none

package gpdc_pkg;

    // request direction
    localparam logic MODE_G2S = 1'b0;
    localparam logic MODE_S2G = 1'b1;

    typedef enum logic {
        CAL_GREG  = 1'b0,
        CAL_SOLAR = 1'b1
    } cal_t;

    localparam int YEAR_SPAN_DEF   = 51;
    localparam int GREG_BASE_YEAR  = 2000;
    localparam int SOLAR_BASE_YEAR = 1380;
    localparam int GREG_LEAP_BASE  = 499;
    localparam int SOLAR_LEAP_BASE = 343;
    localparam int EPOCH_SHIFT     = 226899;
    localparam int DAYS_PER_YEAR   = 365;
    localparam int GS_YEAR_GAP     = 621;

    localparam int YEAR_W     = 12;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int WDAY_W     = 3;
    localparam int DOY_W      = 9;
    localparam int LCNT_W     = 4;
    localparam int N_W        = 11;
    localparam int BIDX_W     = 6;
    localparam int BOUND_LEN  = 51;
    localparam int MONTHS     = 12;

    // day-of-year offsets once the whole-year part of the count cancels
    localparam int N_G2S_EARLY = (GS_YEAR_GAP + 1) * DAYS_PER_YEAR + GREG_LEAP_BASE
                                 - SOLAR_LEAP_BASE - EPOCH_SHIFT;
    localparam int N_G2S_LATE  = GS_YEAR_GAP * DAYS_PER_YEAR + GREG_LEAP_BASE
                                 - SOLAR_LEAP_BASE - EPOCH_SHIFT;
    localparam int N_S2G_EARLY = EPOCH_SHIFT - GS_YEAR_GAP * DAYS_PER_YEAR
                                 + SOLAR_LEAP_BASE - GREG_LEAP_BASE;
    localparam int N_S2G_LATE  = EPOCH_SHIFT - (GS_YEAR_GAP + 1) * DAYS_PER_YEAR
                                 + SOLAR_LEAP_BASE - GREG_LEAP_BASE;

    // weekday offsets: 365 == 1 mod 7, so only residues of the constants matter
    localparam int WD_OFS_G = ((GREG_BASE_YEAR - 1) % 7 + GREG_LEAP_BASE % 7) % 7;
    localparam int WD_OFS_S = ((SOLAR_BASE_YEAR - 1) % 7 + SOLAR_LEAP_BASE % 7
                              + EPOCH_SHIFT % 7) % 7;

    localparam int GREG_LEAP_N  = 14;
    localparam int SOLAR_LEAP_N = 15;

    localparam logic [YEAR_W-1:0] GREG_LEAPS [GREG_LEAP_N] = '{
        12'd2000, 12'd2004, 12'd2008, 12'd2012, 12'd2016, 12'd2020, 12'd2024,
        12'd2028, 12'd2032, 12'd2036, 12'd2040, 12'd2044, 12'd2048, 12'd2052
    };
    localparam logic [YEAR_W-1:0] SOLAR_LEAPS [SOLAR_LEAP_N] = '{
        12'd1375, 12'd1379, 12'd1383, 12'd1387, 12'd1391, 12'd1395, 12'd1399,
        12'd1404, 12'd1408, 12'd1412, 12'd1416, 12'd1420, 12'd1424, 12'd1428,
        12'd1432
    };

    localparam logic [DAY_W-1:0] GREG_BOUND [BOUND_LEN] = '{
        5'd20, 5'd21, 5'd21, 5'd21, 5'd20, 5'd21, 5'd21, 5'd21, 5'd20, 5'd21,
        5'd21, 5'd21, 5'd20, 5'd21, 5'd21, 5'd21, 5'd20, 5'd21, 5'd21, 5'd21,
        5'd20, 5'd21, 5'd21, 5'd21, 5'd20, 5'd20, 5'd21, 5'd21, 5'd20, 5'd20,
        5'd21, 5'd21, 5'd20, 5'd20, 5'd21, 5'd21, 5'd20, 5'd20, 5'd21, 5'd21,
        5'd20, 5'd20, 5'd21, 5'd21, 5'd20, 5'd20, 5'd21, 5'd21, 5'd20, 5'd20,
        5'd21
    };
    localparam logic [DAY_W-1:0] SOLAR_BOUND [BOUND_LEN] = '{
        5'd11, 5'd11, 5'd11, 5'd12, 5'd11, 5'd11, 5'd11, 5'd12, 5'd11, 5'd11,
        5'd11, 5'd12, 5'd11, 5'd11, 5'd11, 5'd12, 5'd11, 5'd11, 5'd11, 5'd12,
        5'd11, 5'd11, 5'd11, 5'd12, 5'd12, 5'd11, 5'd11, 5'd12, 5'd12, 5'd11,
        5'd11, 5'd12, 5'd12, 5'd11, 5'd11, 5'd12, 5'd12, 5'd11, 5'd11, 5'd12,
        5'd12, 5'd11, 5'd11, 5'd12, 5'd12, 5'd11, 5'd11, 5'd12, 5'd12, 5'd11,
        5'd11
    };

    // cumulative day count at the end of month i, common year
    localparam logic [DOY_W-1:0] GREG_CUM [MONTHS+1] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243,
        9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam logic [DOY_W-1:0] SOLAR_CUM [MONTHS+1] = '{
        9'd0, 9'd31, 9'd62, 9'd93, 9'd124, 9'd155, 9'd186, 9'd216, 9'd246,
        9'd276, 9'd306, 9'd336, 9'd365
    };

    function automatic logic [LCNT_W-1:0] greg_leap_count(input logic [YEAR_W-1:0] yr);
        logic [LCNT_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < GREG_LEAP_N; i++) begin
            if (GREG_LEAPS[i] < yr) cnt = cnt + LCNT_W'(1);
        end
        return cnt;
    endfunction

    function automatic logic [LCNT_W-1:0] solar_leap_count(input logic [YEAR_W-1:0] yr);
        logic [LCNT_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < SOLAR_LEAP_N; i++) begin
            if (SOLAR_LEAPS[i] < yr) cnt = cnt + LCNT_W'(1);
        end
        return cnt;
    endfunction

    function automatic logic greg_is_leap(input logic [YEAR_W-1:0] yr);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < GREG_LEAP_N; i++) begin
            if (GREG_LEAPS[i] == yr) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic logic solar_is_leap(input logic [YEAR_W-1:0] yr);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < SOLAR_LEAP_N; i++) begin
            if (SOLAR_LEAPS[i] == yr) hit = 1'b1;
        end
        return hit;
    endfunction

    // years past the end of the table reuse its last entry
    function automatic logic [DAY_W-1:0] bound_at(input cal_t cal,
                                                  input logic [BIDX_W-1:0] idx);
        logic [BIDX_W-1:0] cidx;
        cidx = (idx >= BIDX_W'(BOUND_LEN)) ? BIDX_W'(BOUND_LEN - 1) : idx;
        return (cal == CAL_SOLAR) ? SOLAR_BOUND[cidx] : GREG_BOUND[cidx];
    endfunction

    // day count at the end of month i, leap day included where it applies
    function automatic logic [DOY_W-1:0] cum_end(input cal_t cal, input logic [MONTH_W-1:0] i,
                                                 input logic leap);
        logic [MONTH_W-1:0] ci;
        logic [DOY_W-1:0]   base;
        logic               add;
        ci   = (i > MONTH_W'(MONTHS)) ? MONTH_W'(MONTHS) : i;
        base = (cal == CAL_SOLAR) ? SOLAR_CUM[ci] : GREG_CUM[ci];
        add  = (cal == CAL_SOLAR) ? (leap && (ci == MONTH_W'(MONTHS)))
                                  : (leap && (ci >= MONTH_W'(2)));
        return base + DOY_W'(add);
    endfunction

endpackage

`default_nettype wire

// File: design/gregorian_persian_date_converter.sv
// Top level of the Gregorian / Solar Hijri date converter pipeline.
// Six register stages lie between an accepted request and m_tvalid.
// Throughput: one request per cycle unless m_tready holds the pipe; a full stage holds while the next cannot load.
// A waiting result does not stop intake until every stage behind it is full.
// Reset (aresetn low, synchronous) clears all stage valid bits; data registers keep junk.
`default_nettype none
`include "gregorian_persian_date_converter_assert.svh"

module gregorian_persian_date_converter
    import gpdc_pkg::*;
#(
    parameter int YEAR_SPAN = YEAR_SPAN_DEF  // supported years per calendar, 1..64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: in_year[11:0], in_month[15:12], in_day[20:16], zero pad [23:21]
    input  wire logic [23:0] s_tdata,
    // s_tuser: mode (0 Gregorian to Solar Hijri, 1 Solar Hijri to Gregorian)
    input  wire logic [0:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: out_year[11:0], out_month[15:12], out_day[20:16], weekday[23:21]
    output logic [23:0]      m_tdata,
    // m_tuser: out_of_range
    output logic [0:0]       m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready
);

    localparam int NSTG = 6;
    // bits of the year offset into the supported span
    localparam int K_W  = (YEAR_SPAN > 1) ? $clog2(YEAR_SPAN) : 1;

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or the stage after
    // it moves on this cycle. Ready ripples back from the output register.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] stg_rdy;

    always_comb begin
        stg_rdy[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            stg_rdy[i] = !vld_reg[i] || stg_rdy[i+1];
        end
        vld_next[0] = stg_rdy[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < NSTG; i++) begin
            vld_next[i] = stg_rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = stg_rdy[0];
    assign m_tvalid = vld_reg[NSTG-1];

    // ------------------------------------------------------------------
    // Stage 1: range check, source leap data, boundary-day lookup and the
    // choice of target year (early or late part of the source year).
    // ------------------------------------------------------------------
    logic [YEAR_W-1:0]  in_year;
    logic [MONTH_W-1:0] in_month;
    logic [DAY_W-1:0]   in_day;
    logic               in_mode;
    logic [YEAR_W-1:0]  base_year;
    logic [YEAR_W-1:0]  year_ofs;
    logic [DAY_W-1:0]   bound_day;
    cal_t               src_cal;

    logic               s1_oor_next,  s1_oor_reg;
    logic               s1_mode_next, s1_mode_reg;
    logic [YEAR_W-1:0]  s1_year_reg;
    logic [MONTH_W-1:0] s1_month_reg;
    logic [DAY_W-1:0]   s1_day_reg;
    logic [K_W-1:0]     s1_k_next,    s1_k_reg;
    logic               s1_leap_next, s1_leap_reg;
    logic [LCNT_W-1:0]  s1_cnt_next,  s1_cnt_reg;
    logic               s1_late_next, s1_late_reg;

    assign in_year  = s_tdata[11:0];
    assign in_month = s_tdata[15:12];
    assign in_day   = s_tdata[20:16];
    assign in_mode  = s_tuser[0];

    always_comb begin
        src_cal   = (in_mode == MODE_S2G) ? CAL_SOLAR : CAL_GREG;
        base_year = (in_mode == MODE_S2G) ? YEAR_W'(SOLAR_BASE_YEAR) : YEAR_W'(GREG_BASE_YEAR);
        year_ofs  = in_year - base_year;
        s1_oor_next = (in_year < base_year) || (year_ofs >= YEAR_W'(YEAR_SPAN))
                      || (in_month == '0) || (in_month > MONTH_W'(MONTHS))
                      || (in_day == '0);
        s1_mode_next = in_mode;
        s1_k_next    = year_ofs[K_W-1:0];
        bound_day    = bound_at(src_cal, BIDX_W'(s1_k_next));
        // leap day only shifts the Gregorian source day of year
        s1_leap_next = (in_mode == MODE_G2S) && greg_is_leap(in_year);
        s1_cnt_next  = (in_mode == MODE_S2G) ? solar_leap_count(in_year)
                                             : greg_leap_count(in_year);
        // late: on or past the boundary day, the target year is one higher
        if (in_mode == MODE_S2G) begin
            s1_late_next = (in_month > MONTH_W'(10))
                           || ((in_month == MONTH_W'(10)) && (in_day >= bound_day));
        end else begin
            s1_late_next = (in_month > MONTH_W'(3))
                           || ((in_month == MONTH_W'(3)) && (in_day >= bound_day));
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[0]) begin
            s1_oor_reg   <= s1_oor_next;
            s1_mode_reg  <= s1_mode_next;
            s1_year_reg  <= in_year;
            s1_month_reg <= in_month;
            s1_day_reg   <= in_day;
            s1_k_reg     <= s1_k_next;
            s1_leap_reg  <= s1_leap_next;
            s1_cnt_reg   <= s1_cnt_next;
            s1_late_reg  <= s1_late_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: source day of year and target year.
    // ------------------------------------------------------------------
    logic               s2_oor_reg;
    logic               s2_mode_reg;
    logic [K_W-1:0]     s2_k_reg;
    logic [LCNT_W-1:0]  s2_cnt_reg;
    logic               s2_late_reg;
    logic [DOY_W-1:0]   s2_doy_next, s2_doy_reg;
    logic [YEAR_W-1:0]  s2_ty_next,  s2_ty_reg;
    cal_t               s1_cal;

    always_comb begin
        s1_cal      = (s1_mode_reg == MODE_S2G) ? CAL_SOLAR : CAL_GREG;
        s2_doy_next = cum_end(s1_cal, s1_month_reg - MONTH_W'(1), s1_leap_reg)
                      + DOY_W'(s1_day_reg);
        if (s1_mode_reg == MODE_S2G) begin
            s2_ty_next = s1_year_reg + YEAR_W'(GS_YEAR_GAP) + YEAR_W'(s1_late_reg);
        end else begin
            s2_ty_next = s1_year_reg - YEAR_W'(GS_YEAR_GAP + 1) + YEAR_W'(s1_late_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[1]) begin
            s2_oor_reg  <= s1_oor_reg;
            s2_mode_reg <= s1_mode_reg;
            s2_k_reg    <= s1_k_reg;
            s2_cnt_reg  <= s1_cnt_reg;
            s2_late_reg <= s1_late_reg;
            s2_doy_reg  <= s2_doy_next;
            s2_ty_reg   <= s2_ty_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: target leap data, partial day residue and weekday sum.
    // The whole-year terms of both day counts cancel to a small constant.
    // ------------------------------------------------------------------
    logic                    s3_oor_reg;
    logic                    s3_mode_reg;
    logic [YEAR_W-1:0]       s3_ty_reg;
    logic [LCNT_W-1:0]       s3_tcnt_next, s3_tcnt_reg;
    logic                    s3_tleap_next, s3_tleap_reg;
    logic signed [N_W-1:0]   s3_npart_next, s3_npart_reg;
    logic [DOY_W-1:0]        s3_wsum_next, s3_wsum_reg;
    logic signed [N_W-1:0]   n_ofs;

    always_comb begin
        if (s2_mode_reg == MODE_S2G) begin
            s3_tcnt_next  = greg_leap_count(s2_ty_reg);
            s3_tleap_next = greg_is_leap(s2_ty_reg);
            n_ofs         = s2_late_reg ? N_W'(N_S2G_LATE) : N_W'(N_S2G_EARLY);
            s3_wsum_next  = DOY_W'(WD_OFS_S);
        end else begin
            s3_tcnt_next  = solar_leap_count(s2_ty_reg);
            s3_tleap_next = solar_is_leap(s2_ty_reg);
            n_ofs         = s2_late_reg ? N_W'(N_G2S_LATE) : N_W'(N_G2S_EARLY);
            s3_wsum_next  = DOY_W'(WD_OFS_G);
        end
        s3_wsum_next  = s3_wsum_next + DOY_W'(s2_k_reg) + s2_doy_reg + DOY_W'(s2_cnt_reg);
        s3_npart_next = $signed(N_W'(s2_doy_reg)) + $signed(N_W'(s2_cnt_reg)) + n_ofs;
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[2]) begin
            s3_oor_reg   <= s2_oor_reg;
            s3_mode_reg  <= s2_mode_reg;
            s3_ty_reg    <= s2_ty_reg;
            s3_tcnt_reg  <= s3_tcnt_next;
            s3_tleap_reg <= s3_tleap_next;
            s3_npart_reg <= s3_npart_next;
            s3_wsum_reg  <= s3_wsum_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: day of target year, weekday by octal digit folding (8 == 1 mod 7).
    // ------------------------------------------------------------------
    logic                    s4_oor_reg;
    logic                    s4_mode_reg;
    logic [YEAR_W-1:0]       s4_ty_reg;
    logic                    s4_tleap_reg;
    logic signed [N_W-1:0]   s4_n_next, s4_n_reg;
    logic [WDAY_W-1:0]       s4_wd_next, s4_wd_reg;
    logic [4:0]              fold_a;
    logic [3:0]              fold_b;
    logic [2:0]              fold_c;

    always_comb begin
        s4_n_next = s3_npart_reg - $signed(N_W'(s3_tcnt_reg));
        fold_a = 5'(s3_wsum_reg[8:6]) + 5'(s3_wsum_reg[5:3]) + 5'(s3_wsum_reg[2:0]);
        fold_b = 4'(fold_a[4:3]) + 4'(fold_a[2:0]);
        fold_c = 3'(fold_b[3]) + fold_b[2:0];
        s4_wd_next = (fold_c == 3'd7) ? '0 : fold_c;
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[3]) begin
            s4_oor_reg   <= s3_oor_reg;
            s4_mode_reg  <= s3_mode_reg;
            s4_ty_reg    <= s3_ty_reg;
            s4_tleap_reg <= s3_tleap_reg;
            s4_n_reg     <= s4_n_next;
            s4_wd_reg    <= s4_wd_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: month walk as parallel compares against month ends.
    // ------------------------------------------------------------------
    logic                    s5_oor_reg;
    logic                    s5_mode_reg;
    logic [YEAR_W-1:0]       s5_ty_reg;
    logic                    s5_tleap_reg;
    logic signed [N_W-1:0]   s5_n_reg;
    logic [WDAY_W-1:0]       s5_wd_reg;
    logic                    s5_low_next, s5_low_reg;
    logic                    s5_high_next, s5_high_reg;
    logic [MONTH_W-1:0]      s5_mon_next, s5_mon_reg;
    cal_t                    s4_tcal;

    always_comb begin
        s4_tcal     = (s4_mode_reg == MODE_S2G) ? CAL_GREG : CAL_SOLAR;
        s5_low_next = s4_n_reg < $signed(N_W'(1));
        s5_high_next = s4_n_reg > $signed(N_W'(cum_end(s4_tcal, MONTH_W'(MONTHS),
                                                       s4_tleap_reg)));
        s5_mon_next = MONTH_W'(1);
        for (int i = 1; i < MONTHS; i++) begin
            if (s4_n_reg > $signed(N_W'(cum_end(s4_tcal, MONTH_W'(i), s4_tleap_reg)))) begin
                s5_mon_next = s5_mon_next + MONTH_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[4]) begin
            s5_oor_reg   <= s4_oor_reg;
            s5_mode_reg  <= s4_mode_reg;
            s5_ty_reg    <= s4_ty_reg;
            s5_tleap_reg <= s4_tleap_reg;
            s5_n_reg     <= s4_n_reg;
            s5_wd_reg    <= s4_wd_reg;
            s5_low_reg   <= s5_low_next;
            s5_high_reg  <= s5_high_next;
            s5_mon_reg   <= s5_mon_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6 (output register): day within month, saturation when the
    // residue falls outside the year, zeros for an out-of-range request.
    // ------------------------------------------------------------------
    logic [YEAR_W-1:0]       out_year_next,  out_year_reg;
    logic [MONTH_W-1:0]      out_month_next, out_month_reg;
    logic [DAY_W-1:0]        out_day_next,   out_day_reg;
    logic [WDAY_W-1:0]       weekday_next,   weekday_reg;
    logic                    oor_next,       oor_reg;
    logic signed [N_W-1:0]   day_rem;
    cal_t                    s5_tcal;

    always_comb begin
        s5_tcal = (s5_mode_reg == MODE_S2G) ? CAL_GREG : CAL_SOLAR;
        day_rem = s5_n_reg - $signed(N_W'(cum_end(s5_tcal, s5_mon_reg - MONTH_W'(1),
                                                  s5_tleap_reg)));
        out_year_next  = s5_ty_reg;
        weekday_next   = s5_wd_reg;
        oor_next       = s5_oor_reg;
        if (s5_low_reg) begin
            out_month_next = MONTH_W'(1);
            out_day_next   = DAY_W'(1);
        end else if (s5_high_reg) begin
            out_month_next = MONTH_W'(MONTHS);
            out_day_next   = DAY_W'(31);
        end else begin
            out_month_next = s5_mon_reg;
            out_day_next   = day_rem[DAY_W-1:0];
        end
        if (s5_oor_reg) begin
            out_year_next  = '0;
            out_month_next = '0;
            out_day_next   = '0;
            weekday_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[5]) begin
            out_year_reg  <= out_year_next;
            out_month_reg <= out_month_next;
            out_day_reg   <= out_day_next;
            weekday_reg   <= weekday_next;
            oor_reg       <= oor_next;
        end
    end

    assign m_tdata = {weekday_reg, out_day_reg, out_month_reg, out_year_reg};
    assign m_tuser = oor_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a rejected request carries an all-zero date
    `GPDC_ASSERT_NOW(a_oor_zero, m_tvalid && m_tuser[0], m_tdata == '0)
    // an accepted request always yields a real month and weekday
    `GPDC_ASSERT_NOW(a_month_ok, m_tvalid && !m_tuser[0],
        (m_tdata[15:12] != 4'd0) && (m_tdata[15:12] <= 4'd12) && (m_tdata[23:21] != 3'd7))
    // with the output register empty, intake never stalls
    `GPDC_ASSERT_NOW(a_ready_empty, !vld_reg[NSTG-1], s_tready)
    // a blocked middle stage keeps its item
    `GPDC_ASSERT_NEXT(a_mid_hold, vld_reg[2] && !stg_rdy[2],
        vld_reg[2] && $stable(s3_ty_reg) && $stable(s3_npart_reg))

endmodule

`default_nettype wire
